// ----- hw/rtl/rrar_pkg.sv -----
// Shared types and constants for the relative-to-absolute rectangle converter.
// Used by rrar_div, rel_rect_to_abs_rect and the test files; no dependencies of its own.
`default_nettype none
package rrar_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int SIZE_BITS      = 48;
   localparam int DIV_STEP_BITS  = 4;
   localparam int DIV_STAGES     = SIZE_BITS / DIV_STEP_BITS;
   localparam logic [16:0] ANCH_ONE = 17'h10000;
   localparam logic [SIZE_BITS-1:0] SIZE_CAP = '1;

   typedef enum logic [1:0] {
      MODE_PIXEL    = 2'd0,
      MODE_FRACTION = 2'd1,
      MODE_GRID     = 2'd2,
      MODE_INVALID  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_TILE_W       = 3'd0,
      CSR_TILE_H       = 3'd1,
      CSR_RATIO_ENABLE = 3'd2,
      CSR_RATIO_W      = 3'd3,
      CSR_RATIO_H      = 3'd4
   } csr_index_type;

   // Per-request data carried alongside the fill divider
   typedef struct packed {
      logic                 mode_err;
      logic                 fill_w;
      logic                 fill_h;
      logic                 fill_both;
      logic [16:0]          ax;
      logic [16:0]          ay;
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
      logic [51:0]          d0_x;
      logic [51:0]          d0_y;
      logic [31:0]          rg_x;
      logic [31:0]          rg_y;
   } side_type;

   typedef struct packed {
      logic [15:0]          rem;
      logic [SIZE_BITS-1:0] nrest;
      logic [SIZE_BITS-1:0] q;
      logic                 cap;
      logic [15:0]          den;
   } div_stage_type;

endpackage
`default_nettype wire

// ----- hw/rtl/rrar_div.sv -----
// Pipelined restoring divider for the ratio fill: 64-bit numerator by 16-bit
// divisor, quotient capped to 48 bits, DIV_STEP_BITS quotient bits per stage.
// Depends on rrar_pkg.
`default_nettype none
module rrar_div import rrar_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [63:0]          in_num,
   input  wire logic [15:0]          in_den,
   input  wire side_type             in_side,
   output logic                      out_valid,
   output logic [SIZE_BITS-1:0]      out_quot,
   output side_type                  out_side
);

   div_stage_type stage_ff [DIV_STAGES];
   div_stage_type stage_in [DIV_STAGES];
   side_type      side_ff  [DIV_STAGES];
   logic          valid_ff [DIV_STAGES];
   div_stage_type entry;

   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type o;
      logic [16:0]   t;
      o = s;
      for (int j = 0; j < DIV_STEP_BITS; j++) begin
         t = {o.rem, o.nrest[SIZE_BITS-1]};
         o.nrest = {o.nrest[SIZE_BITS-2:0], 1'b0};
         if (t >= {1'b0, o.den}) begin
            o.rem = 16'(t - {1'b0, o.den});
            o.q = {o.q[SIZE_BITS-2:0], 1'b1};
         end else begin
            o.rem = t[15:0];
            o.q = {o.q[SIZE_BITS-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   always_comb begin
      // quotient of 2^48 or more saturates; otherwise the top word is below den
      entry.rem   = in_num[63:48];
      entry.nrest = in_num[SIZE_BITS-1:0];
      entry.q     = '0;
      entry.cap   = (in_num[63:48] >= in_den);
      entry.den   = in_den;
      for (int k = 0; k < DIV_STAGES; k++) begin
         stage_in[k] = div_step((k == 0) ? entry : stage_ff[(k == 0) ? 0 : k - 1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
            side_ff[k]  <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            valid_ff[k] <= (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quot  = stage_ff[DIV_STAGES-1].cap ? SIZE_CAP : stage_ff[DIV_STAGES-1].q;
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- hw/rtl/rel_rect_to_abs_rect.sv -----
// Relative-to-absolute rectangle converter, top level. Depends on rrar_pkg, rrar_div.
// Stages from request acceptance to rsp_tvalid: 4 front stages, 12 divider
// stages, 4 back stages. Throughput: one request per cycle; the
// pipeline stalls as a whole only while the output register holds an untaken result.
// Reset: synchronous, clears all valid bits and loads the register defaults
// (tiles 1, ratio fill off, ratio 1:1).
`default_nettype none
module rel_rect_to_abs_rect import rrar_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // rel_x, rel_y, rel_w, rel_h, anchor_x, anchor_y, base_x, base_y, base_w, base_h
   input  wire logic [231:0] req_tdata,
   // coord_mode
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // abs_x, abs_y, abs_w, abs_h
   output logic [63:0]       rsp_tdata,
   // mode_error
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   logic en;

   // configuration
   logic [15:0] tile_w_ff, tile_h_ff, ratio_w_ff, ratio_h_ff;
   logic        ratio_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_w_ff   <= 16'd1;
         tile_h_ff   <= 16'd1;
         ratio_en_ff <= 1'b0;
         ratio_w_ff  <= 16'd1;
         ratio_h_ff  <= 16'd1;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TILE_W:       tile_w_ff   <= csr_wdata;
            CSR_TILE_H:       tile_h_ff   <= csr_wdata;
            CSR_RATIO_ENABLE: ratio_en_ff <= csr_wdata[0];
            CSR_RATIO_W:      ratio_w_ff  <= csr_wdata;
            CSR_RATIO_H:      ratio_h_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: capture, clamp anchors
   logic        s1_valid_ff;
   mode_type    s1_mode_ff;
   logic [31:0] s1_rx_ff, s1_ry_ff, s1_rw_ff, s1_rh_ff;
   logic [16:0] s1_ax_ff, s1_ay_ff;
   logic [15:0] s1_bx_ff, s1_by_ff, s1_bw_ff, s1_bh_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mode_ff <= mode_type'(req_tuser);
         s1_rx_ff   <= req_tdata[31:0];
         s1_ry_ff   <= req_tdata[63:32];
         s1_rw_ff   <= req_tdata[95:64];
         s1_rh_ff   <= req_tdata[127:96];
         s1_ax_ff   <= (req_tdata[144:128] > ANCH_ONE) ? ANCH_ONE : req_tdata[144:128];
         s1_ay_ff   <= (req_tdata[161:145] > ANCH_ONE) ? ANCH_ONE : req_tdata[161:145];
         s1_bx_ff   <= req_tdata[177:162];
         s1_by_ff   <= req_tdata[193:178];
         s1_bw_ff   <= req_tdata[209:194];
         s1_bh_ff   <= req_tdata[225:210];
      end
   end

   // stage 2: size products, relative-position products, anchor*tile
   logic        s2_valid_ff;
   mode_type    s2_mode_ff;
   logic [31:0] s2_rx_ff, s2_ry_ff;
   logic [16:0] s2_ax_ff, s2_ay_ff;
   logic [15:0] s2_bx_ff, s2_by_ff;
   logic [SIZE_BITS-1:0] s2_w_ff, s2_h_ff, s2_w_in, s2_h_in;
   logic signed [48:0]   s2_px_ff, s2_py_ff, s2_px_in, s2_py_in;
   logic [32:0]          s2_at_x_ff, s2_at_y_ff;
   logic [15:0]          dim_x, dim_y;

   always_comb begin
      dim_x = (s1_mode_ff == MODE_FRACTION) ? s1_bw_ff : tile_w_ff;
      dim_y = (s1_mode_ff == MODE_FRACTION) ? s1_bh_ff : tile_h_ff;
      s2_w_in = (s1_mode_ff == MODE_PIXEL) ? {16'd0, s1_rw_ff} : s1_rw_ff * dim_x;
      s2_h_in = (s1_mode_ff == MODE_PIXEL) ? {16'd0, s1_rh_ff} : s1_rh_ff * dim_y;
      s2_px_in = $signed(s1_rx_ff) * $signed({1'b0, dim_x});
      s2_py_in = $signed(s1_ry_ff) * $signed({1'b0, dim_y});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_mode_ff <= s1_mode_ff;
         s2_rx_ff   <= s1_rx_ff;
         s2_ry_ff   <= s1_ry_ff;
         s2_ax_ff   <= s1_ax_ff;
         s2_ay_ff   <= s1_ay_ff;
         s2_bx_ff   <= s1_bx_ff;
         s2_by_ff   <= s1_by_ff;
         s2_w_ff    <= s2_w_in;
         s2_h_ff    <= s2_h_in;
         s2_px_ff   <= s2_px_in;
         s2_py_ff   <= s2_py_in;
         s2_at_x_ff <= s1_ax_ff * tile_w_ff;
         s2_at_y_ff <= s1_ay_ff * tile_h_ff;
      end
   end

   // stage 3: exact position base terms, fill select, split fill product
   logic        s3_valid_ff;
   side_type    s3_side_ff, s3_side_in;
   logic [47:0] s3_phi_ff;
   logic [31:0] s3_plo_ff;
   logic [15:0] s3_den_ff, fill_mul, fill_den;
   logic [SIZE_BITS-1:0] fill_num;
   logic        wz, hz;

   function automatic logic [51:0] pos_base(mode_type m, logic [15:0] b, logic [31:0] rel,
                                            logic signed [48:0] prod, logic [32:0] at,
                                            logic [15:0] tile);
      logic [51:0] t;
      logic [51:0] g;
      t = (m == MODE_PIXEL) ? {{20{rel[31]}}, rel} : {{3{prod[48]}}, prod};
      g = (m == MODE_GRID) ? (52'({at[32:16], 16'd0}) - 52'({tile, 16'd0})) : 52'd0;
      return {{20{b[15]}}, b, 16'd0} + t + g;
   endfunction

   always_comb begin
      wz = (s2_w_ff == '0);
      hz = (s2_h_ff == '0);
      s3_side_in.mode_err  = (s2_mode_ff == MODE_INVALID);
      s3_side_in.fill_both = ratio_en_ff & wz & hz;
      s3_side_in.fill_w    = ratio_en_ff & wz & ~hz;
      s3_side_in.fill_h    = ratio_en_ff & hz & ~wz;
      s3_side_in.ax   = s2_ax_ff;
      s3_side_in.ay   = s2_ay_ff;
      s3_side_in.w    = s2_w_ff;
      s3_side_in.h    = s2_h_ff;
      s3_side_in.d0_x = pos_base(s2_mode_ff, s2_bx_ff, s2_rx_ff, s2_px_ff, s2_at_x_ff,
                                 tile_w_ff);
      s3_side_in.d0_y = pos_base(s2_mode_ff, s2_by_ff, s2_ry_ff, s2_py_ff, s2_at_y_ff,
                                 tile_h_ff);
      s3_side_in.rg_x = (s2_mode_ff == MODE_GRID) ? {s2_at_x_ff[15:0], 16'd0} : 32'd0;
      s3_side_in.rg_y = (s2_mode_ff == MODE_GRID) ? {s2_at_y_ff[15:0], 16'd0} : 32'd0;
      fill_num = s3_side_in.fill_w ? s2_h_ff : s2_w_ff;
      fill_mul = s3_side_in.fill_w ? ratio_w_ff : ratio_h_ff;
      fill_den = s3_side_in.fill_w ? ratio_h_ff : ratio_w_ff;
      if (fill_den == 16'd0) fill_den = 16'd1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_side_ff <= s3_side_in;
         s3_phi_ff  <= fill_num[47:16] * fill_mul;
         s3_plo_ff  <= fill_num[15:0] * fill_mul;
         s3_den_ff  <= fill_den;
      end
   end

   // stage 4: assemble the 64-bit fill numerator
   logic        s4_valid_ff;
   side_type    s4_side_ff;
   logic [63:0] s4_num_ff;
   logic [15:0] s4_den_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_side_ff <= s3_side_ff;
         s4_num_ff  <= {s3_phi_ff, 16'd0} + {32'd0, s3_plo_ff};
         s4_den_ff  <= s3_den_ff;
      end
   end

   logic                 dv_valid;
   logic [SIZE_BITS-1:0] dv_quot;
   side_type             dv_side;

   rrar_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_num    (s4_num_ff),
      .in_den    (s4_den_ff),
      .in_side   (s4_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // stage 5: resolve final sizes
   logic        s5_valid_ff;
   side_type    s5_side_ff, s5_side_in;

   always_comb begin
      s5_side_in = dv_side;
      if (dv_side.fill_both) begin
         s5_side_in.w = {16'd0, ratio_w_ff, 16'd0};
         s5_side_in.h = {16'd0, ratio_h_ff, 16'd0};
      end else if (dv_side.fill_w) begin
         s5_side_in.w = dv_quot;
      end else if (dv_side.fill_h) begin
         s5_side_in.h = dv_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (en) s5_side_ff <= s5_side_in;
   end

   // stage 6: anchor*size products, rounded sizes
   logic        s6_valid_ff;
   side_type    s6_side_ff;
   logic [48:0] s6_awh_x_ff, s6_awh_y_ff;
   logic [32:0] s6_awl_x_ff, s6_awl_y_ff;
   logic [15:0] s6_sw_ff, s6_sh_ff;
   logic [SIZE_BITS:0] rw_sum, rh_sum;

   always_comb begin
      rw_sum = {1'b0, s5_side_ff.w} + (49'd1 << (FRAC_BITS - 1));
      rh_sum = {1'b0, s5_side_ff.h} + (49'd1 << (FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_side_ff  <= s5_side_ff;
         s6_awh_x_ff <= s5_side_ff.ax * s5_side_ff.w[47:16];
         s6_awh_y_ff <= s5_side_ff.ay * s5_side_ff.h[47:16];
         s6_awl_x_ff <= s5_side_ff.ax * s5_side_ff.w[15:0];
         s6_awl_y_ff <= s5_side_ff.ay * s5_side_ff.h[15:0];
         s6_sw_ff <= (rw_sum[48:32] != 17'd0) ? 16'hFFFF : rw_sum[31:16];
         s6_sh_ff <= (rh_sum[48:32] != 17'd0) ? 16'hFFFF : rh_sum[31:16];
      end
   end

   // stage 7: position sums before the final shift
   logic        s7_valid_ff;
   logic        s7_err_ff;
   logic [51:0] s7_sum_x_ff, s7_sum_y_ff;
   logic [15:0] s7_sw_ff, s7_sh_ff;

   function automatic logic [51:0] pos_sum(logic [51:0] d0, logic [31:0] rg,
                                           logic [48:0] awh, logic [32:0] awl);
      logic signed [35:0] r;
      logic signed [35:0] r_sh;
      r = $signed({4'd0, rg}) - $signed({3'd0, awl}) + 36'sh0_8000_0000;
      r_sh = r >>> 16;
      return d0 - {3'd0, awh} + {{16{r_sh[35]}}, r_sh};
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         s7_err_ff   <= s6_side_ff.mode_err;
         s7_sum_x_ff <= pos_sum(s6_side_ff.d0_x, s6_side_ff.rg_x, s6_awh_x_ff, s6_awl_x_ff);
         s7_sum_y_ff <= pos_sum(s6_side_ff.d0_y, s6_side_ff.rg_y, s6_awh_y_ff, s6_awl_y_ff);
         s7_sw_ff    <= s6_sw_ff;
         s7_sh_ff    <= s6_sh_ff;
      end
   end

   // stage 8: output register with saturation
   logic        out_valid_ff;
   logic        out_err_ff;
   logic [15:0] out_x_ff, out_y_ff, out_w_ff, out_h_ff;

   function automatic logic [15:0] sat16(logic [51:0] s);
      logic signed [35:0] v;
      v = $signed(s[51:16]);
      if (v > 36'sd32767) return 16'h7FFF;
      if (v < -36'sd32768) return 16'h8000;
      return v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         out_err_ff <= s7_err_ff;
         out_x_ff   <= s7_err_ff ? 16'd0 : sat16(s7_sum_x_ff);
         out_y_ff   <= s7_err_ff ? 16'd0 : sat16(s7_sum_y_ff);
         out_w_ff   <= s7_err_ff ? 16'd0 : s7_sw_ff;
         out_h_ff   <= s7_err_ff ? 16'd0 : s7_sh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= dv_valid;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         out_valid_ff <= s7_valid_ff;
      end
   end

   // whole pipe advances unless a result is waiting to be taken
   assign en         = ~out_valid_ff | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_h_ff, out_w_ff, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("mode error result carries nonzero fields");

   a_fill_flags: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && (s4_side_ff.fill_w || s4_side_ff.fill_h || s4_side_ff.fill_both)
      |-> ratio_en_ff && $countones({s4_side_ff.fill_w, s4_side_ff.fill_h,
                                     s4_side_ff.fill_both}) == 1)
      else $error("inconsistent ratio fill selection");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without a held result");

endmodule
`default_nettype wire

// ----- test/rel_rect_to_abs_rect_check.sv -----
// Checker for rel_rect_to_abs_rect: watches request, response and register channels,
// predicts each response and compares. Depends on rrar_pkg.
`timescale 1ns / 1ps
module rel_rect_to_abs_rect_check import rrar_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [231:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,
   input  wire logic [0:0]   rsp_tuser,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   output int                fail_count,
   output int                pending,
   output int                rect_count
);

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic        err;
   } rect_type;

   rect_type rect_queue[$];

   logic [15:0] tile_w, tile_h, ratio_w, ratio_h;
   logic        ratio_en;

   localparam longint unsigned FILL_CAP = (64'd1 << 48) - 1;

   function automatic logic [15:0] axis_round(logic [1:0] mode, longint base, longint rel,
                                              longint bdim, longint tile, longint a,
                                              longint w);
      longint d, r, v, t;
      d = base * 65536;
      if (mode == MODE_PIXEL) begin
         d += rel;
      end else if (mode == MODE_FRACTION) begin
         d += rel * bdim;
      end else begin
         t = a * tile;
         d += rel * tile - tile * 65536;
         d += (t >>> 16) <<< 16;
      end
      d -= a * (w >>> 16);
      r = -(a * (w & 65535));
      if (mode == MODE_GRID) r += ((a * tile) & 65535) <<< 16;
      r += longint'(1) <<< 31;
      v = (d + (r >>> 16)) >>> 16;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic logic [15:0] size_round(longint unsigned w);
      longint unsigned p;
      p = (w + 32768) >> 16;
      return (p > 65535) ? 16'hFFFF : p[15:0];
   endfunction

   // wraps mod 2^64 on the product, like the defining arithmetic
   function automatic longint unsigned ratio_fill(longint unsigned num, longint unsigned mul,
                                                  longint unsigned div);
      longint unsigned q;
      if (div == 0) div = 1;
      q = (num * mul) / div;
      return (q > FILL_CAP) ? FILL_CAP : q;
   endfunction

   function automatic rect_type predict_rect(logic [1:0] mode, logic [231:0] d);
      rect_type        e;
      longint unsigned w, h, rw, rh, bw, bh, ax, ay;
      rw = d[95:64];
      rh = d[127:96];
      ax = d[144:128];
      ay = d[161:145];
      bw = d[209:194];
      bh = d[225:210];
      e = '0;
      if (mode == MODE_INVALID) begin
         e.err = 1'b1;
         return e;
      end
      if (ax > ANCH_ONE) ax = ANCH_ONE;
      if (ay > ANCH_ONE) ay = ANCH_ONE;
      if (mode == MODE_PIXEL) begin
         w = rw; h = rh;
      end else if (mode == MODE_FRACTION) begin
         w = rw * bw; h = rh * bh;
      end else begin
         w = rw * tile_w; h = rh * tile_h;
      end
      if (ratio_en) begin
         if (w == 0 && h == 0) begin
            w = longint'(ratio_w) << 16;
            h = longint'(ratio_h) << 16;
         end else if (w == 0) begin
            w = ratio_fill(h, ratio_w, ratio_h);
         end else if (h == 0) begin
            h = ratio_fill(w, ratio_h, ratio_w);
         end
      end
      e.x = axis_round(mode, longint'($signed(d[177:162])), longint'($signed(d[31:0])),
                       longint'(bw), longint'(tile_w), longint'(ax), longint'(w));
      e.y = axis_round(mode, longint'($signed(d[193:178])), longint'($signed(d[63:32])),
                       longint'(bh), longint'(tile_h), longint'(ay), longint'(h));
      e.w = size_round(w);
      e.h = size_round(h);
      return e;
   endfunction

   assign pending = rect_queue.size();

   always @(posedge clock) begin
      rect_type e, a;
      if (reset) begin
         tile_w <= 16'd1;
         tile_h <= 16'd1;
         ratio_en <= 1'b0;
         ratio_w <= 16'd1;
         ratio_h <= 16'd1;
         fail_count <= 0;
         rect_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TILE_W:       tile_w <= csr_wdata;
               CSR_TILE_H:       tile_h <= csr_wdata;
               CSR_RATIO_ENABLE: ratio_en <= csr_wdata[0];
               CSR_RATIO_W:      ratio_w <= csr_wdata;
               CSR_RATIO_H:      ratio_h <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            rect_count <= rect_count + 1;
            a.x = rsp_tdata[15:0];
            a.y = rsp_tdata[31:16];
            a.w = rsp_tdata[47:32];
            a.h = rsp_tdata[63:48];
            a.err = rsp_tuser[0];
            if (rect_queue.size() == 0) begin
               $display("%0t: response with no request pending: x=%h y=%h w=%h h=%h err=%b",
                        $time, a.x, a.y, a.w, a.h, a.err);
               fail_count <= fail_count + 1;
            end else begin
               e = rect_queue.pop_front();
               if (e !== a) begin
                  $display("%0t: mismatch expected x=%h y=%h w=%h h=%h err=%b", $time,
                           e.x, e.y, e.w, e.h, e.err);
                  $display("%0t:          actual   x=%h y=%h w=%h h=%h err=%b", $time,
                           a.x, a.y, a.w, a.h, a.err);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) rect_queue.push_back(predict_rect(req_tuser, req_tdata));
      end
   end

endmodule

// ----- test/rel_rect_to_abs_rect_test.sv -----
// Top of the rel_rect_to_abs_rect testbench: clock, reset, stimulus and verdict.
// Depends on rrar_pkg, rel_rect_to_abs_rect and rel_rect_to_abs_rect_check.
`timescale 1ns / 1ps
module rel_rect_to_abs_rect_test import rrar_pkg::*; ();

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [231:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   int fail_count, pending, rect_count;
   int send_idle = 0;
   int recv_stall = 0;
   int sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rel_rect_to_abs_rect u_dut (.*);

   rel_rect_to_abs_rect_check u_check (.*);

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall);

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(logic [15:0] tw, logic [15:0] th, logic [15:0] en,
                           logic [15:0] rw, logic [15:0] rh);
      write_reg(CSR_TILE_W, tw);
      write_reg(CSR_TILE_H, th);
      write_reg(CSR_RATIO_ENABLE, en);
      write_reg(CSR_RATIO_W, rw);
      write_reg(CSR_RATIO_H, rh);
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   // called at a falling edge; returns at a falling edge after acceptance
   task automatic send_rect(logic [1:0] mode, logic [31:0] rx, logic [31:0] ry,
                            logic [31:0] rw, logic [31:0] rh, logic [16:0] ax,
                            logic [16:0] ay, logic [15:0] bx, logic [15:0] by,
                            logic [15:0] bw, logic [15:0] bh);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tuser <= mode;
      req_tdata <= {6'b0, bh, bw, by, bx, ay, ax, rh, rw, ry, rx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   function automatic logic [31:0] pick_pos();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(4000)) - 2000) << 16;
         2: return {16'($signed($urandom_range(200)) - 100), 16'($urandom())};
         default: return 32'($urandom_range(8)) << 16;
      endcase
   endfunction

   function automatic logic [31:0] pick_size();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'd0;
         2: return 32'($urandom_range(2000)) << 16;
         3: return $urandom_range(65536 * 4);
         default: return {16'($urandom_range(300)), 16'($urandom())};
      endcase
   endfunction

   function automatic logic [16:0] pick_anchor();
      case ($urandom_range(4))
         0: return 17'd0;
         1: return ANCH_ONE;
         2: return 17'($urandom());
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   task automatic send_random();
      logic [1:0] mode;
      mode = ($urandom_range(15) == 0) ? MODE_INVALID : 2'($urandom_range(2));
      send_rect(mode, pick_pos(), pick_pos(), pick_size(), pick_size(),
                pick_anchor(), pick_anchor(), 16'($urandom()), 16'($urandom()),
                ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(64)),
                ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(64)));
   endtask

   initial begin
      #200000;
      $display("timeout: %0d requests sent, %0d outstanding", sent, pending);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: each mode, field extremes, ratio fill cases, anchor above one
      set_regs(16'd3, 16'd5, 16'd1, 16'd4, 16'd3);
      send_rect(MODE_PIXEL, 32'h000A_8000, 32'h0014_0000, 32'h0020_0000, 32'h0010_0000,
                17'd0, 17'd0, 16'd5, 16'd7, 16'd0, 16'd0);
      send_rect(MODE_FRACTION, 32'h0000_8000, 32'h0000_4000, 32'h0000_8000, 32'h0001_0000,
                17'h08000, 17'h10000, 16'd10, 16'd20, 16'd100, 16'd50);
      send_rect(MODE_GRID, 32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000,
                17'h08000, 17'h04000, 16'd0, 16'd0, 16'd0, 16'd0);
      send_rect(MODE_INVALID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                17'h1FFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_rect(MODE_PIXEL, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                17'h1FFFF, 17'h10001, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
      send_rect(MODE_FRACTION, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                17'd0, 17'h10000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
      send_rect(MODE_GRID, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                17'h10000, 17'd1, 16'h8000, 16'h7FFF, 16'd0, 16'd0);
      send_rect(MODE_PIXEL, 32'd0, 32'd0, 32'd0, 32'd0, 17'h10000, 17'h10000,
                16'd0, 16'd0, 16'd0, 16'd0);
      send_rect(MODE_PIXEL, 32'd0, 32'd0, 32'd0, 32'h0006_0000, 17'h08000, 17'h08000,
                16'd1, 16'd1, 16'd0, 16'd0);
      send_rect(MODE_PIXEL, 32'd0, 32'd0, 32'h0008_0000, 32'd0, 17'h08000, 17'h08000,
                16'd1, 16'd1, 16'd0, 16'd0);
      send_rect(MODE_FRACTION, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                17'd0, 17'd0, 16'd0, 16'd0, 16'd0, 16'd9);
      send_rect(MODE_PIXEL, 32'h0000_7FFF, 32'hFFFF_8000, 32'h0000_7FFF, 32'h0000_8000,
                17'd0, 17'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_rect(MODE_PIXEL, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 17'd0, 17'd0,
                16'd0, 16'd0, 16'd0, 16'd0);
      req_tvalid <= 1'b0;
      drain();
      // zero tile and zero ratio divisor
      set_regs(16'd0, 16'd0, 16'd1, 16'd0, 16'd0);
      send_rect(MODE_GRID, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'd0,
                17'h08000, 17'h08000, 16'd3, 16'd4, 16'd0, 16'd0);
      send_rect(MODE_PIXEL, 32'd0, 32'd0, 32'd0, 32'h0003_0000, 17'd0, 17'd0,
                16'd0, 16'd0, 16'd0, 16'd0);
      send_rect(MODE_PIXEL, 32'd0, 32'd0, 32'h0003_0000, 32'd0, 17'd0, 17'd0,
                16'd0, 16'd0, 16'd0, 16'd0);
      req_tvalid <= 1'b0;
      drain();

      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            0: set_regs(16'd1, 16'd1, 16'd0, 16'd1, 16'd1);
            1: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: set_regs(16'd0, 16'd0, 16'd1, 16'd0, 16'd0);
            3: set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
            default: set_regs(($urandom_range(1)) ? 16'($urandom()) : 16'($urandom_range(64)),
                              ($urandom_range(1)) ? 16'($urandom()) : 16'($urandom_range(64)),
                              16'($urandom()), 16'($urandom()), 16'($urandom()));
         endcase
         case (seg % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 78; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 78; end
            default: begin send_idle = 34; recv_stall = 34; end
         endcase
         repeat (206) send_random();
         req_tvalid <= 1'b0;
         drain();
         recv_stall = 0;
      end

      $display("covered %0d requests, %0d responses checked, across 10 register settings",
               sent, rect_count);
      $display("and four idle/stall patterns on both channels");
      if (fail_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
